@@ rtl/gwcs_pkg.sv @@
// Shared constants, types and state codes for the grid window capture store.
`timescale 1ns / 1ps

package gwcs_pkg;

  // Store size and coordinate width
  localparam int STORE_DEPTH = 65536;
  localparam int COORD_BITS  = 16;

  // Fixed port widths
  localparam int FIELD_W   = 16;
  localparam int DATA_W    = 8;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 3;

  // Derived widths
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int PROD2_W = 2 * COORD_BITS;
  localparam int WIDE_W  = (3 * COORD_BITS > CNT_W) ? 3 * COORD_BITS : CNT_W;

  // Command queue between front and back (power of two)
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_LOAD  = 2'd1,
    OP_READ  = 2'd2,
    OP_FILL  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_I_LOW    = 3'd0,
    REG_WIN_J_LOW    = 3'd1,
    REG_WIN_K_LOW    = 3'd2,
    REG_WIN_I_COUNT  = 3'd3,
    REG_WIN_J_COUNT  = 3'd4,
    REG_WIN_K_COUNT  = 3'd5,
    REG_GRID_I_COUNT = 3'd6,
    REG_GRID_J_COUNT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [FIELD_W-1:0] win_i_low;
    logic [FIELD_W-1:0] win_j_low;
    logic [FIELD_W-1:0] win_k_low;
    logic [FIELD_W-1:0] win_i_count;
    logic [FIELD_W-1:0] win_j_count;
    logic [FIELD_W-1:0] win_k_count;
    logic [FIELD_W-1:0] grid_i_count;
    logic [FIELD_W-1:0] grid_j_count;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data;
    logic              in_win;
    coord_t            di;
    coord_t            dj;
    coord_t            dk;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_MUL2,
    B_SUM,
    B_MEM,
    B_RDWAIT,
    B_FILL,
    B_DONE
  } back_state_t;

endpackage

@@ rtl/gwcs_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module gwcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/gwcs_queue.sv @@
// Small command queue between the front and back sections.
`timescale 1ns / 1ps

module gwcs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gwcs_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output gwcs_pkg::cmd_t dout,
  output logic           empty
);
  import gwcs_pkg::*;

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ rtl/gwcs_front.sv @@
// Front section: accept items, track the raster position, classify against the window.
`timescale 1ns / 1ps

module gwcs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic [gwcs_pkg::OP_W-1:0]     in_op,
  input  logic [gwcs_pkg::DATA_W-1:0]   in_data,
  input  logic [gwcs_pkg::FIELD_W-1:0]  in_i_pos,
  input  logic [gwcs_pkg::FIELD_W-1:0]  in_j_pos,
  input  logic [gwcs_pkg::FIELD_W-1:0]  in_k_pos,
  output logic                          in_full,
  input  gwcs_pkg::cfg_t                cfg,
  input  logic                          q_full,
  output logic                          q_push,
  output gwcs_pkg::cmd_t                q_cmd
);
  import gwcs_pkg::*;

  coord_t              i_follow_r, i_follow_nxt;
  coord_t              j_follow_r, j_follow_nxt;
  coord_t              k_follow_r, k_follow_nxt;
  op_t                 op;
  logic                accept;
  coord_t              pos_i, pos_j, pos_k;
  coord_t              ilo, jlo, klo, ic, jc, kc, gi, gj;
  coord_t              rel_i, rel_j, rel_k;
  logic                in_i, in_j, in_k, three_d;
  logic [COORD_BITS:0] ni, nj;
  logic                i_wrap, j_wrap;

  assign op      = op_t'(in_op);
  assign accept  = in_push && !q_full;
  assign in_full = q_full;
  assign q_push  = accept;

  assign ilo = coord_t'(cfg.win_i_low);
  assign jlo = coord_t'(cfg.win_j_low);
  assign klo = coord_t'(cfg.win_k_low);
  assign ic  = coord_t'(cfg.win_i_count);
  assign jc  = coord_t'(cfg.win_j_count);
  assign kc  = coord_t'(cfg.win_k_count);
  assign gi  = coord_t'(cfg.grid_i_count);
  assign gj  = coord_t'(cfg.grid_j_count);

  // Loads use the raster position, reads carry their own
  assign pos_i = (op == OP_LOAD) ? i_follow_r : coord_t'(in_i_pos);
  assign pos_j = (op == OP_LOAD) ? j_follow_r : coord_t'(in_j_pos);
  assign pos_k = (op == OP_LOAD) ? k_follow_r : coord_t'(in_k_pos);

  assign rel_i   = pos_i - ilo;
  assign rel_j   = pos_j - jlo;
  assign rel_k   = pos_k - klo;
  assign in_i    = (pos_i >= ilo) && (rel_i < ic);
  assign in_j    = (pos_j >= jlo) && (rel_j < jc);
  assign in_k    = (pos_k >= klo) && (rel_k < kc);
  assign three_d = (kc != '0);

  always_comb begin
    q_cmd.op     = op;
    q_cmd.data   = in_data;
    q_cmd.in_win = in_i && in_j && (!three_d || in_k);
    q_cmd.di     = rel_i;
    q_cmd.dj     = rel_j;
    q_cmd.dk     = three_d ? rel_k : '0;
  end

  // Raster stepping: i wraps into j, j wraps into k, k saturates
  assign ni     = {1'b0, i_follow_r} + 1'b1;
  assign nj     = {1'b0, j_follow_r} + 1'b1;
  assign i_wrap = (ni >= {1'b0, gi});
  assign j_wrap = (nj >= {1'b0, gj});

  always_comb begin
    i_follow_nxt = i_follow_r;
    j_follow_nxt = j_follow_r;
    k_follow_nxt = k_follow_r;
    if (accept) begin
      unique case (op)
        OP_START: begin
          i_follow_nxt = '0;
          j_follow_nxt = '0;
          k_follow_nxt = '0;
        end
        OP_LOAD: begin
          if (i_wrap) begin
            i_follow_nxt = '0;
            if (j_wrap) begin
              j_follow_nxt = '0;
              if (k_follow_r != '1) begin
                k_follow_nxt = k_follow_r + 1'b1;
              end
            end else begin
              j_follow_nxt = nj[COORD_BITS-1:0];
            end
          end else begin
            i_follow_nxt = ni[COORD_BITS-1:0];
          end
        end
        OP_READ, OP_FILL: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_follow_r <= '0;
      j_follow_r <= '0;
      k_follow_r <= '0;
    end else begin
      i_follow_r <= i_follow_nxt;
      j_follow_r <= j_follow_nxt;
      k_follow_r <= k_follow_nxt;
    end
  end

endmodule

@@ rtl/gwcs_back.sv @@
// Back section: address arithmetic, store access, fill walk and result register.
`timescale 1ns / 1ps

module gwcs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gwcs_pkg::cfg_t              cfg,
  input  logic                        q_empty,
  input  gwcs_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [gwcs_pkg::DATA_W-1:0] out_read_data,
  output logic                        out_hit
);
  import gwcs_pkg::*;

  back_state_t        state_r, state_nxt;
  cmd_t               cmd_r;
  logic [PROD2_W-1:0] plane_r, prod_ji_r;
  logic [WIDE_W-1:0]  prod_k_r, addr_r;
  logic [CNT_W-1:0]   fill_end_r, fill_cnt_r;
  logic [DATA_W-1:0]  res_data_r, out_data_r;
  logic               res_hit_r, out_hit_r, out_valid_r;

  coord_t             ic, jc, kc, kc_eff, mult_a;
  logic               in_store, out_load, out_take;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [DATA_W-1:0]  ram_rdata;

  localparam logic [WIDE_W-1:0] DEPTH_WIDE = WIDE_W'(STORE_DEPTH);
  localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(STORE_DEPTH);

  assign ic       = coord_t'(cfg.win_i_count);
  assign jc       = coord_t'(cfg.win_j_count);
  assign kc       = coord_t'(cfg.win_k_count);
  assign kc_eff   = (kc == '0) ? coord_t'(1) : kc;
  assign mult_a   = (cmd_r.op == OP_FILL) ? kc_eff : cmd_r.dk;
  assign in_store = cmd_r.in_win && (addr_r < DEPTH_WIDE);
  assign out_take = out_pop && out_valid_r;

  gwcs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cmd_r.data),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr_r[ADDR_W-1:0];
    out_load  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = (q_cmd.op == OP_START) ? B_DONE : B_MUL;
        end
      end
      B_MUL:  state_nxt = B_MUL2;
      B_MUL2: state_nxt = B_SUM;
      B_SUM:  state_nxt = (cmd_r.op == OP_FILL) ? B_FILL : B_MEM;
      B_MEM: begin
        ram_we    = (cmd_r.op == OP_LOAD) && in_store;
        state_nxt = ((cmd_r.op == OP_READ) && in_store) ? B_RDWAIT : B_DONE;
      end
      B_RDWAIT: state_nxt = B_DONE;
      B_FILL: begin
        if (fill_cnt_r < fill_end_r) begin
          ram_we   = 1'b1;
          ram_addr = fill_cnt_r[ADDR_W-1:0];
        end else begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_take) begin
          out_load  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r      <= q_cmd;
      res_data_r <= (q_cmd.op == OP_START) ? '0 : q_cmd.data;
      res_hit_r  <= ((q_cmd.op == OP_LOAD) || (q_cmd.op == OP_READ)) && q_cmd.in_win;
    end
    if (state_r == B_MUL) begin
      plane_r   <= PROD2_W'(jc) * PROD2_W'(ic);
      prod_ji_r <= PROD2_W'(cmd_r.dj) * PROD2_W'(ic);
    end
    if (state_r == B_MUL2) begin
      prod_k_r <= WIDE_W'(mult_a) * WIDE_W'(plane_r);
    end
    if (state_r == B_SUM) begin
      addr_r     <= prod_k_r + WIDE_W'(prod_ji_r) + WIDE_W'(cmd_r.di);
      fill_cnt_r <= '0;
      fill_end_r <= (prod_k_r < DEPTH_WIDE) ? prod_k_r[CNT_W-1:0] : DEPTH_CNT;
      if (cmd_r.op == OP_FILL) begin
        res_hit_r <= (prod_k_r != '0);
      end
    end
    if ((state_r == B_MEM) && (cmd_r.op == OP_READ) && cmd_r.in_win && !in_store) begin
      res_data_r <= '0;
    end
    if (state_r == B_RDWAIT) begin
      res_data_r <= ram_rdata;
    end
    if ((state_r == B_FILL) && ram_we) begin
      fill_cnt_r <= fill_cnt_r + 1'b1;
    end
    if (out_load) begin
      out_data_r <= res_data_r;
      out_hit_r  <= res_hit_r;
    end
  end

  assign out_empty     = !out_valid_r;
  assign out_read_data = out_data_r;
  assign out_hit       = out_hit_r;

endmodule

@@ rtl/grid_window_capture_store_top.sv @@
// Top level of the grid window capture store.
`timescale 1ns / 1ps

// Grid window capture store: keeps the bytes of one rectangular window of
// a 2-D or 3-D grid in a single-port byte RAM.
// Input channel (push / full): one beat per item. A start beat clears
// the raster position, a load beat carries the next grid byte in raster
// order, a read beat looks up a grid-relative position, a fill beat writes
// its byte to every window entry. Each beat yields exactly one result beat.
// Result channel (empty / pop): read_data and hit of the oldest
// result, held until popped.
// Config channel (valid / ready): always ready; write only while
// no beat is in flight.
// The back sequencer takes one item at a time. A start beat goes
// straight to the result step; every other beat takes two multiply
// steps and one add step, then the RAM access, with a wait for the
// read data on reads that hit inside the store. A fill walks the
// window (capped at the store depth) in place of the RAM access.
// The front keeps accepting into a two-entry command queue while the back
// works and while a finished result waits; when the queue fills, full
// rises and holds the sender. A stalled receiver stops the back after its
// current item.
// Reset clears the raster position, the queue and the result register and
// loads the window registers with zero counts and unit grid counts. Store
// contents are not cleared; read only entries that were loaded or filled.

module grid_window_capture_store_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic [gwcs_pkg::OP_W-1:0]        in_op,
  input  logic [gwcs_pkg::DATA_W-1:0]      in_data,
  input  logic [gwcs_pkg::FIELD_W-1:0]     in_i_pos,
  input  logic [gwcs_pkg::FIELD_W-1:0]     in_j_pos,
  input  logic [gwcs_pkg::FIELD_W-1:0]     in_k_pos,
  output logic                             empty,
  input  logic                             pop,
  output logic [gwcs_pkg::DATA_W-1:0]      out_read_data,
  output logic                             out_hit,
  input  logic                             valid,
  output logic                             ready,
  input  logic [gwcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gwcs_pkg::FIELD_W-1:0]     cfg_data
);
  import gwcs_pkg::*;

  cfg_t cfg_r;
  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_in, q_out;

  assign ready = 1'b1;

  // Window and grid registers; grid counts reset to one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{grid_i_count: FIELD_W'(1), grid_j_count: FIELD_W'(1), default: '0};
    end else if (valid && ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIN_I_LOW:    cfg_r.win_i_low    <= cfg_data;
        REG_WIN_J_LOW:    cfg_r.win_j_low    <= cfg_data;
        REG_WIN_K_LOW:    cfg_r.win_k_low    <= cfg_data;
        REG_WIN_I_COUNT:  cfg_r.win_i_count  <= cfg_data;
        REG_WIN_J_COUNT:  cfg_r.win_j_count  <= cfg_data;
        REG_WIN_K_COUNT:  cfg_r.win_k_count  <= cfg_data;
        REG_GRID_I_COUNT: cfg_r.grid_i_count <= cfg_data;
        REG_GRID_J_COUNT: cfg_r.grid_j_count <= cfg_data;
      endcase
    end
  end

  // Front: classify and advance the raster position
  gwcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (push),
    .in_op    (in_op),
    .in_data  (in_data),
    .in_i_pos (in_i_pos),
    .in_j_pos (in_j_pos),
    .in_k_pos (in_k_pos),
    .in_full  (full),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  // Decouple the two sections
  gwcs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  // Back: address math, store access, fill walk, result register
  gwcs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_empty       (q_empty),
    .q_cmd         (q_out),
    .q_pop         (q_pop),
    .out_empty     (empty),
    .out_pop       (pop),
    .out_read_data (out_read_data),
    .out_hit       (out_hit)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the grid window capture store top level.
`timescale 1ns / 1ps

module tb_top;
  import gwcs_pkg::*;

  // Bound on run length; the slowest legal run stays far below this.
  localparam int CYCLE_LIMIT = 3_000_000;
  // Settle time after the last result, above the longest fixed latency.
  localparam int SETTLE_CYCLES = 20;
  // Fills in the random part stay at or below this many entries to keep runs short.
  localparam int FILL_CAP = 4096;
  // Length of the long receiver hold-off that backs up the block.
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1600;
  localparam int TAIL_ITEMS = 150;
  localparam longint unsigned COORD_MAX = (64'd1 << COORD_BITS) - 1;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              hit;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 push = 1'b0;
  logic                 full;
  logic [OP_W-1:0]      in_op = OP_START;
  logic [DATA_W-1:0]    in_data = '0;
  logic [FIELD_W-1:0]   in_i_pos = '0;
  logic [FIELD_W-1:0]   in_j_pos = '0;
  logic [FIELD_W-1:0]   in_k_pos = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [DATA_W-1:0]    out_read_data;
  logic                 out_hit;
  logic                 valid = 1'b0;
  logic                 ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WIN_I_LOW;
  logic [FIELD_W-1:0]   cfg_data = '0;

  // Predicted state: window registers, raster position and the byte store.
  // mem_set marks entries that were loaded or filled, so that no read ever
  // lands on an entry the block has never written.
  logic [FIELD_W-1:0] cfg_regs [8];
  logic [FIELD_W-1:0] cfg_plan [8];
  logic [COORD_BITS-1:0] i_trk = '0;
  logic [COORD_BITS-1:0] j_trk = '0;
  logic [COORD_BITS-1:0] k_trk = '0;
  logic [DATA_W-1:0] win_mem [STORE_DEPTH];
  bit                mem_set [STORE_DEPTH];

  answer_t answer_q[$];
  int      items_sent = 0;
  int      results_seen = 0;
  int      errors = 0;
  int      cycle_count = 0;

  // Idle bursts on both sides; cleared for the stall test and the tail.
  bit bursts_on = 1'b1;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int stall_left = 0;

  grid_window_capture_store_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_op        (in_op),
    .in_data      (in_data),
    .in_i_pos     (in_i_pos),
    .in_j_pos     (in_j_pos),
    .in_k_pos     (in_k_pos),
    .empty        (empty),
    .pop          (pop),
    .out_read_data(out_read_data),
    .out_hit      (out_hit),
    .valid        (valid),
    .ready        (ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               answer_q.size());
      $display("[grid_window_capture_store_top] ERROR");
      $finish;
    end
  end

  // Map a grid-relative position into the window; hand back the linear
  // window address when it lies inside.
  function automatic bit window_locate(input logic [FIELD_W-1:0] ip, jp, kp,
                                       output longint unsigned addr);
    longint unsigned i, j, k, ilo, jlo, klo, ic, jc, kc;
    i = ip;
    j = jp;
    k = kp;
    ilo = cfg_regs[REG_WIN_I_LOW];
    jlo = cfg_regs[REG_WIN_J_LOW];
    klo = cfg_regs[REG_WIN_K_LOW];
    ic = cfg_regs[REG_WIN_I_COUNT];
    jc = cfg_regs[REG_WIN_J_COUNT];
    kc = cfg_regs[REG_WIN_K_COUNT];
    addr = 0;
    if (i < ilo || i - ilo >= ic) return 1'b0;
    if (j < jlo || j - jlo >= jc) return 1'b0;
    addr = (j - jlo) * ic + (i - ilo);
    // A zero k count means 2-D: the k coordinate plays no part.
    if (kc != 0) begin
      if (k < klo || k - klo >= kc) return 1'b0;
      addr += (k - klo) * (jc * ic);
    end
    return 1'b1;
  endfunction

  function automatic longint unsigned window_size();
    longint unsigned kc;
    kc = cfg_regs[REG_WIN_K_COUNT];
    return longint'(cfg_regs[REG_WIN_I_COUNT]) * longint'(cfg_regs[REG_WIN_J_COUNT]) *
           (kc != 0 ? kc : 64'd1);
  endfunction

  // Work out the result of one accepted item and update predicted state.
  function automatic answer_t store_answer(input op_t op, input logic [DATA_W-1:0] data,
                                           input logic [FIELD_W-1:0] ip, jp, kp);
    answer_t ans;
    longint unsigned addr, size, n, ni, nj;
    ans.read_data = '0;
    ans.hit = 1'b0;
    case (op)
      OP_START: begin
        i_trk = '0;
        j_trk = '0;
        k_trk = '0;
      end
      OP_LOAD: begin
        ans.read_data = data;
        if (window_locate(i_trk, j_trk, k_trk, addr)) begin
          ans.hit = 1'b1;
          // Drop writes past the end of the store, but still report the hit.
          if (addr < STORE_DEPTH) begin
            win_mem[addr] = data;
            mem_set[addr] = 1'b1;
          end
        end
        // Advance in raster order: i wraps into j, j into k, k saturates.
        // A zero grid count wraps at once, the same as a count of one.
        ni = longint'(i_trk) + 1;
        if (ni >= cfg_regs[REG_GRID_I_COUNT] || ni > COORD_MAX) begin
          ni = 0;
          nj = longint'(j_trk) + 1;
          if (nj >= cfg_regs[REG_GRID_J_COUNT] || nj > COORD_MAX) begin
            nj = 0;
            if (k_trk != COORD_MAX) k_trk = k_trk + 1'b1;
          end
          j_trk = COORD_BITS'(nj);
        end
        i_trk = COORD_BITS'(ni);
      end
      OP_READ: begin
        ans.read_data = data;
        if (window_locate(ip, jp, kp, addr)) begin
          ans.hit = 1'b1;
          ans.read_data = (addr < STORE_DEPTH) ? win_mem[addr] : '0;
        end
      end
      default: begin
        size = window_size();
        n = (size < STORE_DEPTH) ? size : STORE_DEPTH;
        for (int a = 0; a < n; a++) begin
          win_mem[a] = data;
          mem_set[a] = 1'b1;
        end
        ans.read_data = data;
        ans.hit = (size != 0);
      end
    endcase
    return ans;
  endfunction

  // Offer one item, hold it until the block takes it, then record what it
  // must produce.
  task automatic send_item(input op_t op, input logic [DATA_W-1:0] data,
                           input logic [FIELD_W-1:0] ip, jp, kp);
    longint unsigned addr;
    // Steer a read away from a never-written entry: move i just outside.
    if (op == OP_READ && window_locate(ip, jp, kp, addr) && addr < STORE_DEPTH &&
        !mem_set[addr])
      ip = (cfg_regs[REG_WIN_I_LOW] != 0) ? cfg_regs[REG_WIN_I_LOW] - 1'b1 : '1;
    if (bursts_on && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    push <= 1'b1;
    in_op <= op;
    in_data <= data;
    in_i_pos <= ip;
    in_j_pos <= jp;
    in_k_pos <= kp;
    do @(posedge clk); while (full);
    answer_q.push_back(store_answer(op, data, ip, jp, kp));
    items_sent++;
  endtask

  // Stop offering and wait until every result is back and the block is quiet.
  task automatic drain_results();
    push <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight window registers from cfg_plan, one beat each, keeping
  // valid high across the run of beats.
  task automatic write_window();
    cfg_reg_t r;
    r = REG_WIN_I_LOW;
    repeat (r.num()) begin
      valid <= 1'b1;
      cfg_index <= r;
      cfg_data <= cfg_plan[r];
      do @(posedge clk); while (!ready);
      cfg_regs[r] = cfg_plan[r];
      r = r.next();
    end
    valid <= 1'b0;
  endtask

  function automatic logic [FIELD_W-1:0] near_coord(input logic [FIELD_W-1:0] lo, cnt);
    case ($urandom_range(0, 9))
      0: return FIELD_W'($urandom_range(0, 65535));
      1: return lo - 1'b1;
      default: return lo + FIELD_W'($urandom_range(0, cnt));
    endcase
  endfunction

  // Pick a window: mostly small grids with the window in or just past the
  // grid, some with zero grid counts, some with extreme register values.
  task automatic load_random_window();
    int gi, gj, mode;
    mode = $urandom_range(0, 9);
    if (mode < 8) begin
      gi = $urandom_range(1, 12);
      gj = $urandom_range(1, 8);
      cfg_plan[REG_GRID_I_COUNT] = FIELD_W'(gi);
      cfg_plan[REG_GRID_J_COUNT] = FIELD_W'(gj);
      cfg_plan[REG_WIN_I_LOW] = FIELD_W'($urandom_range(0, gi - 1));
      cfg_plan[REG_WIN_J_LOW] = FIELD_W'($urandom_range(0, gj - 1));
      cfg_plan[REG_WIN_K_LOW] = FIELD_W'($urandom_range(0, 2));
      cfg_plan[REG_WIN_I_COUNT] =
        FIELD_W'($urandom_range(0, gi - cfg_plan[REG_WIN_I_LOW] + 1));
      cfg_plan[REG_WIN_J_COUNT] =
        FIELD_W'($urandom_range(0, gj - cfg_plan[REG_WIN_J_LOW] + 1));
      cfg_plan[REG_WIN_K_COUNT] = FIELD_W'($urandom_range(0, 3));
      if (mode == 7) begin
        if ($urandom_range(0, 1)) cfg_plan[REG_GRID_I_COUNT] = '0;
        else cfg_plan[REG_GRID_J_COUNT] = '0;
      end
    end else begin
      foreach (cfg_plan[r])
        case ($urandom_range(0, 2))
          0: cfg_plan[r] = '0;
          1: cfg_plan[r] = '1;
          default: cfg_plan[r] = FIELD_W'($urandom_range(0, 65535));
        endcase
    end
    drain_results();
    write_window();
  endtask

  // A well-formed capture: optional fill, start, then a raster of loads
  // mixed with reads around the window and a little noise.
  task automatic run_mixed_items(input int n);
    int pick;
    logic [FIELD_W-1:0] ilo, jlo, klo, ic, jc, kc;
    ilo = cfg_regs[REG_WIN_I_LOW];
    jlo = cfg_regs[REG_WIN_J_LOW];
    klo = cfg_regs[REG_WIN_K_LOW];
    ic = cfg_regs[REG_WIN_I_COUNT];
    jc = cfg_regs[REG_WIN_J_COUNT];
    kc = cfg_regs[REG_WIN_K_COUNT];
    if ($urandom_range(0, 1) && window_size() <= FILL_CAP)
      send_item(OP_FILL, $urandom_range(0, 255), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535));
    send_item(OP_START, $urandom_range(0, 255), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 80 && pick >= 55)
        send_item(OP_READ, $urandom_range(0, 255), near_coord(ilo, ic), near_coord(jlo, jc),
                  near_coord(klo, kc));
      else if (pick < 87 && pick >= 80)
        send_item(OP_READ, $urandom_range(0, 255), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
      else if (pick < 93 && pick >= 87)
        send_item(OP_START, $urandom_range(0, 255), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
      else if (pick >= 93 && window_size() <= FILL_CAP)
        send_item(OP_FILL, $urandom_range(0, 255), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
      else
        send_item(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
    end
  endtask

  // Reset values give an empty window: nothing lands, reads miss, and a
  // fill of an empty window reports no hit.
  task automatic test_reset_window();
    send_item(OP_START, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_LOAD, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_READ, 8'hA5, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_FILL, 8'h00, 16'h0000, 16'h0000, 16'h0000);
  endtask

  // 2-D window of 2x2 at i=1 inside a 4x3 grid; k low is set to its top
  // value to show that k does not matter in 2-D mode.
  task automatic test_window_2d();
    cfg_plan[REG_WIN_I_LOW] = 16'd1;
    cfg_plan[REG_WIN_J_LOW] = 16'd0;
    cfg_plan[REG_WIN_K_LOW] = 16'hFFFF;
    cfg_plan[REG_WIN_I_COUNT] = 16'd2;
    cfg_plan[REG_WIN_J_COUNT] = 16'd2;
    cfg_plan[REG_WIN_K_COUNT] = 16'd0;
    cfg_plan[REG_GRID_I_COUNT] = 16'd4;
    cfg_plan[REG_GRID_J_COUNT] = 16'd3;
    drain_results();
    write_window();
    send_item(OP_START, 8'h11, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_LOAD, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_LOAD, 8'hFF, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_LOAD, 8'h5A, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_LOAD, 8'h80, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_LOAD, 8'h01, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_LOAD, 8'hA5, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_LOAD, 8'h3C, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_LOAD, 8'h7F, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_READ, 8'h00, 16'h0001, 16'h0000, 16'hFFFF);
    send_item(OP_READ, 8'h00, 16'h0002, 16'h0001, 16'h0000);
    send_item(OP_READ, 8'hFF, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_READ, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
  endtask

  // 3-D window of 256x256x4 is larger than the store. With zero grid
  // counts every load steps k, so the second load sits past the store and
  // is dropped; the fill stops at the store depth.
  task automatic test_store_limits();
    cfg_plan[REG_WIN_I_LOW] = 16'd0;
    cfg_plan[REG_WIN_J_LOW] = 16'd0;
    cfg_plan[REG_WIN_K_LOW] = 16'd0;
    cfg_plan[REG_WIN_I_COUNT] = 16'd256;
    cfg_plan[REG_WIN_J_COUNT] = 16'd256;
    cfg_plan[REG_WIN_K_COUNT] = 16'd4;
    cfg_plan[REG_GRID_I_COUNT] = 16'd0;
    cfg_plan[REG_GRID_J_COUNT] = 16'd0;
    drain_results();
    write_window();
    send_item(OP_START, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_LOAD, 8'h5A, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_LOAD, 8'hC3, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_READ, 8'hEE, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_READ, 8'hEE, 16'h0000, 16'h0000, 16'h0001);
    send_item(OP_FILL, 8'h81, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_READ, 8'h00, 16'h00FF, 16'h00FF, 16'h0000);
  endtask

  // Hold the receiver off for a long stretch while the sender keeps
  // offering, so the command queue fills and full holds the sender.
  task automatic test_full_stall();
    load_random_window();
    bursts_on = 1'b0;
    hold_req++;
    run_mixed_items(40);
    bursts_on = 1'b1;
  endtask

  task automatic test_random_windows();
    while (items_sent < RANDOM_ITEMS) begin
      load_random_window();
      run_mixed_items($urandom_range(20, 80));
    end
  endtask

  // Close with back-to-back traffic: no idling on either side.
  task automatic test_steady_stream();
    load_random_window();
    bursts_on = 1'b0;
    run_mixed_items(TAIL_ITEMS);
  endtask

  // Result side: check each popped beat against the oldest expectation,
  // then decide whether to pop on the next edge.
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (answer_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("result %0d arrived with none expected: read_data %0h hit %0b",
                     results_seen, out_read_data, out_hit);
        end else begin
          want = answer_q.pop_front();
          if (out_read_data !== want.read_data) begin
            errors++;
            if (errors <= 10)
              $display("result %0d read_data mismatch: expected %0h got %0h", results_seen,
                       want.read_data, out_read_data);
          end
          if (out_hit !== want.hit) begin
            errors++;
            if (errors <= 10)
              $display("result %0d hit mismatch: expected %0b got %0b", results_seen,
                       want.hit, out_hit);
          end
        end
      end
      // Start a long hold-off when the stall test asks for one.
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    // Mirror the reset values of the window registers.
    foreach (cfg_regs[r]) cfg_regs[r] = '0;
    cfg_regs[REG_GRID_I_COUNT] = 16'd1;
    cfg_regs[REG_GRID_J_COUNT] = 16'd1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_window();
    test_window_2d();
    test_store_limits();
    test_full_stall();
    test_random_windows();
    test_steady_stream();
    drain_results();
    if (errors == 0 && answer_q.size() == 0) begin
      $display("[grid_window_capture_store_top] OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, answer_q.size());
      $display("[grid_window_capture_store_top] ERROR");
    end
    $finish;
  end

endmodule
